// File: hw/rtl/fraction_add_multiply_reduce_top_macros.svh
// ----------------------------------------------------------------------------
// fraction_add_multiply_reduce_top_macros: assertion helpers
// Clocked on clk, quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef FRACTION_ADD_MULTIPLY_REDUCE_TOP_MACROS_SVH
`define FRACTION_ADD_MULTIPLY_REDUCE_TOP_MACROS_SVH

// same-cycle implication
`define FAM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fam assertion failed");

// next-cycle implication
`define FAM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fam assertion failed");

`endif

// File: hw/rtl/fam_pkg.sv
// ----------------------------------------------------------------------------
// fam_pkg: shared types and constants
// Request/result structs, sequencer states and shared-unit opcodes.
// ----------------------------------------------------------------------------
`default_nettype none

package fam_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;      // products, lcm, gcd
  localparam int NUM_WIDTH     = 2 * OPERAND_WIDTH + 1;  // result numerator
  localparam int ALU_WIDTH     = 2 * OPERAND_WIDTH + 2;  // room for sign of difference
  localparam int CNT_WIDTH     = $clog2(PROD_WIDTH + 1);

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_MUL = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [OPERAND_WIDTH-1:0] num_a;
    logic [OPERAND_WIDTH-1:0] den_a;
    logic [OPERAND_WIDTH-1:0] num_b;
    logic [OPERAND_WIDTH-1:0] den_b;
  } fam_req_t;

  typedef struct packed {
    logic [NUM_WIDTH-1:0]  num_out;
    logic [PROD_WIDTH-1:0] den_out;
    logic                  error;
  } fam_rsp_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } fam_alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_Q,
    S_GCD_EVEN,
    S_GCD_ODD,
    S_GCD_SHL,
    S_DIV_A,
    S_DIV_B,
    S_MUL_1,
    S_MUL_2,
    S_MUL_3,
    S_SUM,
    S_SUM_EQ,
    S_DONE
  } fam_state_t;

  // top -> core
  typedef struct packed {
    logic start;  // request accepted this edge
    logic take;   // result moves to the output register this edge
  } fam_ctl_t;

  // core -> top
  typedef struct packed {
    logic idle;
    logic done;
  } fam_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/fam_alu.sv
// ----------------------------------------------------------------------------
// fam_alu: shared arithmetic unit
// One adder/subtractor and one operand-width multiplier, picked by opcode.
// ----------------------------------------------------------------------------
`default_nettype none

module fam_alu (
  input  wire fam_pkg::fam_alu_op_t           op,
  input  wire logic [fam_pkg::ALU_WIDTH-1:0]  x,
  input  wire logic [fam_pkg::ALU_WIDTH-1:0]  y,
  output logic      [fam_pkg::ALU_WIDTH-1:0]  res
);

  localparam int W  = fam_pkg::OPERAND_WIDTH;
  localparam int PW = fam_pkg::PROD_WIDTH;
  localparam int AW = fam_pkg::ALU_WIDTH;

  logic [PW-1:0] prod;

  assign prod = x[W-1:0] * y[W-1:0];

  always_comb begin
    case (op)
      fam_pkg::ALU_ADD: res = x + y;
      fam_pkg::ALU_SUB: res = x - y;   // MSB set when x < y
      fam_pkg::ALU_MUL: res = AW'(prod);
      default:          res = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/fam_core.sv
// ----------------------------------------------------------------------------
// fam_core: fraction sequencer and datapath
// Binary GCD, restoring division and products, all through one fam_alu.
// ----------------------------------------------------------------------------
`default_nettype none

module fam_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fam_pkg::fam_ctl_t ctl,
  input  wire fam_pkg::fam_req_t req,
  output fam_pkg::fam_sts_t      sts,
  output fam_pkg::fam_rsp_t      rsp
);

  localparam int W  = fam_pkg::OPERAND_WIDTH;
  localparam int PW = fam_pkg::PROD_WIDTH;
  localparam int NW = fam_pkg::NUM_WIDTH;
  localparam int AW = fam_pkg::ALU_WIDTH;
  localparam int CW = fam_pkg::CNT_WIDTH;

  fam_pkg::fam_state_t  state, state_next;
  fam_pkg::fam_req_t    item;
  logic [PW-1:0]        ra, rb, g, rx, rr, d;
  logic [NW-1:0]        n;
  logic [CW-1:0]        cnt;
  logic                 err;

  fam_pkg::fam_alu_op_t alu_op;
  logic [AW-1:0]        alu_x, alu_y, alu_res, neg;
  logic [PW:0]          rem_sh;
  logic [PW-1:0]        rem_next, quo, div_a_src, div_b_src;
  logic                 borrow, last, gcd_zero, is_add;

  fam_alu u_alu (
    .op  (alu_op),
    .x   (alu_x),
    .y   (alu_y),
    .res (alu_res)
  );

  assign borrow    = alu_res[AW-1];
  assign neg       = ~alu_res + AW'(1);
  assign rem_sh    = {rr, rx[PW-1]};
  assign rem_next  = borrow ? rem_sh[PW-1:0] : alu_res[PW-1:0];
  assign quo       = {rx[PW-2:0], ~borrow};
  assign last      = (cnt == CW'(1));
  assign gcd_zero  = (ra == '0) || (rb == '0);
  assign is_add    = (item.mode == fam_pkg::MODE_ADD);
  assign div_a_src = is_add ? PW'(item.den_a) : n[PW-1:0];
  assign div_b_src = is_add ? PW'(item.den_b) : d;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fam_pkg::S_IDLE: begin
        if (ctl.start) begin
          if (req.den_a == '0 || req.den_b == '0) begin
            state_next = fam_pkg::S_DONE;
          end else if (req.mode == fam_pkg::MODE_ADD) begin
            state_next = (req.den_a == req.den_b) ? fam_pkg::S_SUM_EQ
                                                  : fam_pkg::S_GCD_EVEN;
          end else begin
            state_next = fam_pkg::S_MUL_P;
          end
        end
      end
      fam_pkg::S_MUL_P:    state_next = fam_pkg::S_MUL_Q;
      fam_pkg::S_MUL_Q:    state_next = (ra == '0) ? fam_pkg::S_DONE : fam_pkg::S_GCD_EVEN;
      fam_pkg::S_GCD_EVEN: if (ra[0] | rb[0]) state_next = fam_pkg::S_GCD_ODD;
      fam_pkg::S_GCD_ODD:  if (gcd_zero) state_next = fam_pkg::S_GCD_SHL;
      fam_pkg::S_GCD_SHL:  if (cnt == '0) state_next = fam_pkg::S_DIV_A;
      fam_pkg::S_DIV_A:    if (last) state_next = fam_pkg::S_DIV_B;
      fam_pkg::S_DIV_B: begin
        if (last) state_next = is_add ? fam_pkg::S_MUL_1 : fam_pkg::S_DONE;
      end
      fam_pkg::S_MUL_1:    state_next = fam_pkg::S_MUL_2;
      fam_pkg::S_MUL_2:    state_next = fam_pkg::S_MUL_3;
      fam_pkg::S_MUL_3:    state_next = fam_pkg::S_SUM;
      fam_pkg::S_SUM:      state_next = fam_pkg::S_DONE;
      fam_pkg::S_SUM_EQ:   state_next = fam_pkg::S_DONE;
      fam_pkg::S_DONE:     if (ctl.take) state_next = fam_pkg::S_IDLE;
      default:             state_next = fam_pkg::S_IDLE;
    endcase
  end

  // shared unit operand select and status
  always_comb begin
    alu_op = fam_pkg::ALU_SUB;
    alu_x  = '0;
    alu_y  = '0;
    case (state)
      fam_pkg::S_MUL_P: begin
        alu_op = fam_pkg::ALU_MUL;
        alu_x  = AW'(item.num_a);
        alu_y  = AW'(item.num_b);
      end
      fam_pkg::S_MUL_Q: begin
        alu_op = fam_pkg::ALU_MUL;
        alu_x  = AW'(item.den_a);
        alu_y  = AW'(item.den_b);
      end
      fam_pkg::S_GCD_ODD: begin
        alu_x = AW'(ra);
        alu_y = AW'(rb);
      end
      fam_pkg::S_DIV_A, fam_pkg::S_DIV_B: begin
        alu_x = AW'(rem_sh);
        alu_y = AW'(g);
      end
      fam_pkg::S_MUL_1: begin
        alu_op = fam_pkg::ALU_MUL;
        alu_x  = AW'(ra);
        alu_y  = AW'(item.den_b);
      end
      fam_pkg::S_MUL_2: begin
        alu_op = fam_pkg::ALU_MUL;
        alu_x  = AW'(item.num_a);
        alu_y  = AW'(rb);
      end
      fam_pkg::S_MUL_3: begin
        alu_op = fam_pkg::ALU_MUL;
        alu_x  = AW'(item.num_b);
        alu_y  = AW'(ra);
      end
      fam_pkg::S_SUM: begin
        alu_op = fam_pkg::ALU_ADD;
        alu_x  = AW'(n);
        alu_y  = AW'(rb);
      end
      fam_pkg::S_SUM_EQ: begin
        alu_op = fam_pkg::ALU_ADD;
        alu_x  = AW'(item.num_a);
        alu_y  = AW'(item.num_b);
      end
      default: begin
        alu_op = fam_pkg::ALU_SUB;
      end
    endcase
  end

  assign sts.idle = (state == fam_pkg::S_IDLE);
  assign sts.done = (state == fam_pkg::S_DONE);
  assign rsp.num_out = n;
  assign rsp.den_out = d;
  assign rsp.error   = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fam_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      fam_pkg::S_IDLE: begin
        if (ctl.start) begin
          item <= req;
          err  <= (req.den_a == '0) || (req.den_b == '0);
          n    <= '0;
          d    <= '0;
          ra   <= PW'(req.den_a);
          rb   <= PW'(req.den_b);
          cnt  <= '0;
        end
      end
      fam_pkg::S_MUL_P: begin
        ra <= alu_res[PW-1:0];
        n  <= NW'(alu_res[PW-1:0]);
      end
      fam_pkg::S_MUL_Q: begin
        if (ra == '0) begin
          d <= PW'(1);  // zero product numerator gives 0/1
        end else begin
          rb <= alu_res[PW-1:0];
          d  <= alu_res[PW-1:0];
        end
      end
      fam_pkg::S_GCD_EVEN: begin
        if (!(ra[0] | rb[0])) begin
          ra  <= ra >> 1;
          rb  <= rb >> 1;
          cnt <= cnt + CW'(1);
        end
      end
      fam_pkg::S_GCD_ODD: begin
        if (gcd_zero) begin
          g <= ra | rb;
        end else if (!ra[0]) begin
          ra <= ra >> 1;
        end else if (!rb[0]) begin
          rb <= rb >> 1;
        end else if (!borrow) begin
          ra <= {1'b0, alu_res[PW-1:1]};
        end else begin
          rb <= {1'b0, neg[PW-1:1]};
        end
      end
      fam_pkg::S_GCD_SHL: begin
        if (cnt == '0) begin
          rx  <= div_a_src;
          rr  <= '0;
          cnt <= CW'(PW);
        end else begin
          g   <= g << 1;
          cnt <= cnt - CW'(1);
        end
      end
      fam_pkg::S_DIV_A: begin
        if (last) begin
          if (is_add) begin
            ra <= quo;
          end else begin
            n <= NW'(quo);
          end
          rx  <= div_b_src;
          rr  <= '0;
          cnt <= CW'(PW);
        end else begin
          rr  <= rem_next;
          rx  <= quo;
          cnt <= cnt - CW'(1);
        end
      end
      fam_pkg::S_DIV_B: begin
        rr  <= rem_next;
        rx  <= quo;
        cnt <= cnt - CW'(1);
        if (last) begin
          if (is_add) begin
            rb <= quo;
          end else begin
            d <= quo;
          end
        end
      end
      fam_pkg::S_MUL_1:  d  <= alu_res[PW-1:0];
      fam_pkg::S_MUL_2:  n  <= NW'(alu_res[PW-1:0]);
      fam_pkg::S_MUL_3:  rb <= alu_res[PW-1:0];
      fam_pkg::S_SUM:    n  <= alu_res[NW-1:0];
      fam_pkg::S_SUM_EQ: begin
        n <= alu_res[NW-1:0];
        d <= PW'(item.den_a);
      end
      default: begin
        err <= err;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/fraction_add_multiply_reduce_top.sv
// Sequence (accepting edge to rsp_valid): a zero denominator goes straight to done, an add
//   with equal denominators makes a single sum, else the run is
//   set by the binary GCD loop and two 32-step divisions.
// Throughput: one request at a time; the next is taken the cycle after the result
//   moves to the output register, which holds it while the consumer stalls.
// Reset: synchronous, active high; sequencer to idle, output register emptied.
// ----------------------------------------------------------------------------
// fraction_add_multiply_reduce_top: fraction add / multiply-and-reduce unit
// Request channel in, one result per request out, valid/stall handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fraction_add_multiply_reduce_top_macros.svh"

module fraction_add_multiply_reduce_top (
  input  wire logic              clk,
  input  wire logic              rst,
  // request channel
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire fam_pkg::fam_req_t req,
  // result channel
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output fam_pkg::fam_rsp_t      rsp
);

  fam_pkg::fam_ctl_t ctl;
  fam_pkg::fam_sts_t sts;
  fam_pkg::fam_rsp_t core_rsp;

  // Busy for the whole of one request; also held off while in reset so a
  // request cannot be dropped on the reset edge.
  assign req_stall = rst || !sts.idle;

  assign ctl.start = req_valid && !req_stall;
  // result leaves the core when the output register is empty or draining
  assign ctl.take  = sts.done && (!rsp_valid || !rsp_stall);

  fam_core u_core (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .req (req),
    .sts (sts),
    .rsp (core_rsp)
  );

  // output register: parts the consumer from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      rsp <= core_rsp;
    end
  end

  // a taken request always moves the sequencer out of idle
  `FAM_ASSERT_NXT(a_start_busy, ctl.start, !sts.idle)
  // a finished result waits in the core until the output register frees up
  `FAM_ASSERT_NXT(a_done_holds, sts.done && !ctl.take, sts.done)
  // error results carry zero numerator and denominator
  `FAM_ASSERT_IMP(a_err_zero, rsp_valid && rsp.error, rsp.num_out == '0 && rsp.den_out == '0)
  // good results never have a zero denominator
  `FAM_ASSERT_IMP(a_den_nonzero, rsp_valid && !rsp.error, rsp.den_out != '0)

endmodule

`default_nettype wire
